// File: rtl/core/sip24s_pkg.sv
// ----------------------------------------------------------------------------
// sip24s_pkg
// Shared types, constants and the SipRound function of the SipHash-2-4 core.
// ----------------------------------------------------------------------------
`default_nettype none

package sip24s_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [WORD_W-1:0] SIP_C0  = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] SIP_C1  = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] SIP_C2  = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] SIP_C3  = 64'h7465646279746573;
  localparam logic [WORD_W-1:0] SIP_FIN = 64'h00000000000000ff;
  localparam int unsigned       LEN_SHIFT = 56;

  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 1'b0,
    CFG_KEY_HIGH = 1'b1
  } cfg_idx_t;

  // What the back end does with one queued word.
  typedef enum logic [1:0] {
    OP_BLOCK     = 2'd0,  // compress msg
    OP_LAST_FULL = 2'd1,  // compress msg, then tail and finalize
    OP_LAST_PART = 2'd2   // compress tail and finalize
  } op_kind_t;

  typedef struct packed {
    logic              init;
    op_kind_t          kind;
    logic [WORD_W-1:0] msg;
    logic [WORD_W-1:0] tail;
  } sip_op_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } lanes_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_M1   = 4'd1,
    ST_M2   = 4'd2,
    ST_T1   = 4'd3,
    ST_T2   = 4'd4,
    ST_F1   = 4'd5,
    ST_F2   = 4'd6,
    ST_F3   = 4'd7,
    ST_F4   = 4'd8
  } bk_state_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned s);
    rotl = (x << s) | (x >> (WORD_W - s));
  endfunction

  function automatic lanes_t sip_round(input lanes_t v);
    lanes_t r;
    r   = v;
    r.a = r.a + r.b;
    r.b = rotl(r.b, 13) ^ r.a;
    r.a = rotl(r.a, 32);
    r.c = r.c + r.d;
    r.d = rotl(r.d, 16) ^ r.c;
    r.a = r.a + r.d;
    r.d = rotl(r.d, 21) ^ r.a;
    r.c = r.c + r.b;
    r.b = rotl(r.b, 17) ^ r.c;
    r.c = rotl(r.c, 32);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sip24s_queue.sv
// ----------------------------------------------------------------------------
// sip24s_queue
// Small FIFO of decoded operations between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module sip24s_queue
  import sip24s_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push_valid,
  output logic         push_ready,
  input  wire sip_op_t push_data,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output sip_op_t      pop_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sip_op_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sip24s_front.sv
// ----------------------------------------------------------------------------
// sip24s_front
// Accepts message words, tracks message start and length, builds tail blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module sip24s_front
  import sip24s_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,   // data_word[63:0], byte_count[67:64]
  input  wire logic                  in_tlast,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output sip_op_t                    q_data
);

  logic             in_msg_r, in_msg_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  logic [WORD_W-1:0]  word;
  logic [COUNT_W-1:0] count_raw;
  logic [COUNT_W-1:0] count;
  logic [LEN_W-1:0]   len_base;
  logic [WORD_W-1:0]  masked;
  logic               accept;

  assign word      = in_tdata[WORD_W-1:0];
  assign count_raw = in_tdata[WORD_W+COUNT_W-1:WORD_W];
  assign in_tready = q_ready;
  assign q_valid   = in_tvalid;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    count    = (count_raw > FULL_COUNT) ? FULL_COUNT : count_raw;
    len_base = in_msg_r ? len_r : '0;
    // keep only the bytes below the count
    for (int i = 0; i < WORD_W / 8; i++) begin
      masked[i*8 +: 8] = (COUNT_W'(i) < count) ? word[i*8 +: 8] : 8'h00;
    end

    q_data.init = !in_msg_r;
    q_data.msg  = word;
    q_data.tail = '0;
    if (!in_tlast) begin
      q_data.kind = OP_BLOCK;
      len_nxt     = len_base + LEN_W'(8);
    end else if (count == FULL_COUNT) begin
      q_data.kind = OP_LAST_FULL;
      len_nxt     = len_base + LEN_W'(8);
      q_data.tail = {len_nxt, {LEN_SHIFT{1'b0}}};
    end else begin
      q_data.kind = OP_LAST_PART;
      len_nxt     = len_base + LEN_W'(count);
      q_data.tail = {len_nxt, masked[LEN_SHIFT-1:0]};
    end
    in_msg_nxt = !in_tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      len_r    <= '0;
    end else if (accept) begin
      in_msg_r <= in_msg_nxt;
      len_r    <= len_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sip24s_back.sv
// ----------------------------------------------------------------------------
// sip24s_back
// Round engine: one SipRound per cycle (held while the output stalls) over queued operations, hash output.
// ----------------------------------------------------------------------------
`default_nettype none

module sip24s_back
  import sip24s_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [WORD_W-1:0]      key_low,
  input  wire logic [WORD_W-1:0]      key_high,
  input  wire logic                   q_valid,
  output logic                        q_ready,
  input  wire sip_op_t                q_data,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  bk_state_t         state_r, state_nxt;
  lanes_t            lanes_r, lanes_nxt;
  sip_op_t           cur_r, cur_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;

  lanes_t            init_lanes, src, pre, rnd, post;
  logic              load_key;
  logic              out_free;
  logic              done;
  logic [WORD_W-1:0] hash;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    init_lanes.a = SIP_C0 ^ key_low;
    init_lanes.b = SIP_C1 ^ key_high;
    init_lanes.c = SIP_C2 ^ key_low;
    init_lanes.d = SIP_C3 ^ key_high;

    // first round of a message starts from the key
    load_key = cur_r.init &&
               ((state_r == ST_M1) ||
                ((state_r == ST_T1) && (cur_r.kind == OP_LAST_PART)));
    src = load_key ? init_lanes : lanes_r;

    pre = src;
    if (state_r == ST_M1) begin
      pre.d = src.d ^ cur_r.msg;
    end else if (state_r == ST_T1) begin
      pre.d = src.d ^ cur_r.tail;
    end

    rnd  = sip_round(pre);
    hash = rnd.a ^ rnd.b ^ rnd.c ^ rnd.d;

    post = rnd;
    if (state_r == ST_M2) begin
      post.a = rnd.a ^ cur_r.msg;
    end else if (state_r == ST_T2) begin
      post.a = rnd.a ^ cur_r.tail;
      post.c = rnd.c ^ SIP_FIN;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    lanes_nxt     = lanes_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    done          = 1'b0;
    q_ready       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        done = 1'b1;
      end
      ST_M1: begin
        lanes_nxt = post;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        lanes_nxt = post;
        if (cur_r.kind == OP_BLOCK) begin
          done = 1'b1;
        end else begin
          state_nxt = ST_T1;
        end
      end
      ST_T1: begin
        lanes_nxt = post;
        state_nxt = ST_T2;
      end
      ST_T2: begin
        lanes_nxt = post;
        state_nxt = ST_F1;
      end
      ST_F1: begin
        lanes_nxt = post;
        state_nxt = ST_F2;
      end
      ST_F2: begin
        lanes_nxt = post;
        state_nxt = ST_F3;
      end
      ST_F3: begin
        lanes_nxt = post;
        state_nxt = ST_F4;
      end
      ST_F4: begin
        // hold the last round until the output register frees up
        if (out_free) begin
          lanes_nxt     = post;
          out_valid_nxt = 1'b1;
          out_data_nxt  = hash;
          done          = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (done) begin
      q_ready = 1'b1;
      if (q_valid) begin
        cur_nxt   = q_data;
        state_nxt = (q_data.kind == OP_LAST_PART) ? ST_T1 : ST_M1;
      end else begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lanes_r    <= lanes_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/siphash_2_4_stream_core.sv
// ----------------------------------------------------------------------------
// siphash_2_4_stream_core
// Keyed SipHash-2-4 over a stream of little-endian 64-bit message words.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                  | handshake
//  in_     | input     | tdata: data_word, byte_count; tlast      | tvalid/tready
//  out_    | output    | tdata: hash_value                        | tvalid/tready
//  cfg_    | input     | cfg_index (key_low, key_high), cfg_wdata | cfg_we
//
//  A non-last word runs the message rounds M1, M2 in the round engine, one SipRound
//  per cycle. A partial last word runs T1, T2, F1-F4 (2 tail + 4 final rounds), a
//  full last word M1, M2 first; the hash is out in the cycle after the last round.
//  The operation queue lets the input run ahead of the round engine; an
//  output stall holds only the final round of a message.
//  Reset (synchronous, active low) empties the queue, clears the keys and
//  drops any open message.
// ----------------------------------------------------------------------------
`default_nettype none

module siphash_2_4_stream_core
  import sip24s_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [WORD_W-1:0]      cfg_wdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,    // data_word[63:0], byte_count[67:64]
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata    // hash_value[63:0]
);

  logic [WORD_W-1:0] key_low_r;
  logic [WORD_W-1:0] key_high_r;

  logic    fq_valid, fq_ready;
  sip_op_t fq_data;
  logic    qb_valid, qb_ready;
  sip_op_t qb_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sip24s_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_data    (fq_data)
  );

  sip24s_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  sip24s_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_low    (key_low_r),
    .key_high   (key_high_r),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_data     (qb_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/sip24s_checker.sv
// ----------------------------------------------------------------------------
// sip24s_checker
// Port-level checks of the SipHash-2-4 core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sip24s_checker
  import sip24s_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // reset leaves an empty queue and no pending hash
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("core not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("hash dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("hash changed while stalled");

  // a hash leaves only by being taken
  a_out_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_tvalid) |-> $past(out_tready))
    else $error("hash withdrawn without transfer");

endmodule

bind siphash_2_4_stream_core sip24s_checker u_sip24s_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
